@@ hdl/abt_pkg.sv @@
// shared types and constants of the address ban table
package abt_pkg;

   typedef enum logic [1:0] {
      OP_CHECK = 2'd0,
      OP_FAIL  = 2'd1,
      OP_OK    = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH,
      ST_POST
   } state_type;

   // configuration register indexes
   localparam logic CSR_MAX_FAILS   = 1'b0;
   localparam logic CSR_BAN_SECONDS = 1'b1;

   localparam logic [7:0]  MAX_FAILS_RESET   = 8'd5;
   localparam logic [31:0] BAN_SECONDS_RESET = 32'd300;
   localparam logic [7:0]  COUNT_MAX         = 8'hFF;

   typedef struct packed {
      logic [32:0] ban_until;
      logic        ban_active;
      logic [7:0]  fail_tally;
      logic [31:0] address;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic       ban_started;
      logic [7:0] fail_total;
      logic       dropped_full;
      logic       is_banned;
   } result_type;

   localparam int RSP_W = 16;

endpackage

@@ hdl/address_ban_table_core.sv @@
// top level of the address ban table
//
// Keeps a table of client IPv4 addresses with failure counts and ban expiry.
// Input channel req_*: tuser carries the opcode (check, fail, ok, clear),
// tdata the address and the current time in seconds. Every transaction
// gives exactly one transaction on the result channel rsp_*.
// The table entries live in one ram; only the per-entry valid bits are
// flops. Check, fail and ok walk all TABLE_ENTRIES entries through the ram
// read port, one entry per cycle, and the ram port sets the pace: the
// result shows once the walk, finish and post states are through, and
// req_tready rises in that same cycle, so no input is taken while an
// earlier one is in work. Clear needs no walk and goes straight to finish.
// A finished result sits in the rsp output register; a new input is
// accepted while it waits. A stalled rsp_tready holds the next result back
// and the block takes no further input until the register frees up.
// Reset (synchronous, active high) empties the table at once and loads
// max_fails = 5 and ban_seconds = 300; csr writes act on the next edge.
module address_ban_table_core #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // client_address[31:0], now_seconds[63:32]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // is_banned[0], dropped_full[1],
                                    // fail_total[9:2], ban_started[10]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);

   abt_pkg::state_type  state_ff, state_in;
   abt_pkg::opcode_type op_ff, op_in;
   logic [31:0]         addr_ff, addr_in;
   logic [31:0]         now_ff, now_in;

   logic [CNT_W-1:0]    issue_cnt_ff, issue_cnt_in;
   logic                proc_vld_ff, proc_vld_in;
   logic [IDX_W-1:0]    proc_idx_ff, proc_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   abt_pkg::entry_type  hit_entry_ff, hit_entry_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;

   logic [7:0]          max_fails_ff;
   logic [31:0]         ban_seconds_ff;

   abt_pkg::result_type pend_ff, pend_in;
   abt_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   abt_pkg::entry_type  ram_wdata;
   logic [IDX_W-1:0]    ram_raddr;
   logic [abt_pkg::ENTRY_W-1:0] ram_rdata;

   abt_pkg::entry_type  rd_entry;
   abt_pkg::entry_type  new_entry;
   abt_pkg::result_type res;
   logic                rd_valid;
   logic                rd_expired;
   logic                rd_live;
   logic [7:0]          base_count;
   logic [7:0]          next_count;
   logic [IDX_W-1:0]    slot;
   logic                req_accept;

   abt_ram #(
      .WIDTH(abt_pkg::ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_entry_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign req_tready = (state_ff == abt_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(abt_pkg::RSP_W - $bits(abt_pkg::result_type))'(0), rsp_data_ff};

   assign rd_entry   = abt_pkg::entry_type'(ram_rdata);
   assign rd_valid   = valid_ff[proc_idx_ff];
   assign rd_expired = rd_valid && rd_entry.ban_active &&
                       ({1'b0, now_ff} >= rd_entry.ban_until);
   // a check drops expired entries before its lookup
   assign rd_live    = rd_valid && !((op_ff == abt_pkg::OP_CHECK) && rd_expired);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      now_in        = now_ff;
      issue_cnt_in  = issue_cnt_ff;
      proc_vld_in   = 1'b0;
      proc_idx_in   = proc_idx_ff;
      valid_in      = valid_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_entry_in  = hit_entry_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      pend_in       = pend_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;
      res           = '0;
      new_entry     = '0;
      base_count    = '0;
      next_count    = '0;
      slot          = '0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         abt_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in        = abt_pkg::opcode_type'(req_tuser);
               addr_in      = req_tdata[31:0];
               now_in       = req_tdata[63:32];
               issue_cnt_in = '0;
               hit_in       = 1'b0;
               free_in      = 1'b0;
               state_in     = (abt_pkg::opcode_type'(req_tuser) == abt_pkg::OP_CLEAR) ?
                              abt_pkg::ST_FINISH : abt_pkg::ST_WALK;
            end
         end
         abt_pkg::ST_WALK: begin
            if (issue_cnt_ff < CNT_END) begin
               ram_raddr    = issue_cnt_ff[IDX_W-1:0];
               proc_vld_in  = 1'b1;
               proc_idx_in  = issue_cnt_ff[IDX_W-1:0];
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            end
            if (proc_vld_ff) begin
               if ((op_ff == abt_pkg::OP_CHECK) && rd_expired) begin
                  valid_in[proc_idx_ff] = 1'b0;
               end
               if (rd_live && (rd_entry.address == addr_ff) && !hit_ff) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = proc_idx_ff;
                  hit_entry_in = rd_entry;
               end
               if (!rd_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = proc_idx_ff;
               end
            end else if (issue_cnt_ff == CNT_END) begin
               state_in = abt_pkg::ST_FINISH;
            end
         end
         abt_pkg::ST_FINISH: begin
            unique case (op_ff)
               abt_pkg::OP_CHECK: begin
                  // expired entries were skipped, so an active ban is unexpired
                  res.is_banned = hit_ff && hit_entry_ff.ban_active;
               end
               abt_pkg::OP_FAIL: begin
                  if (hit_ff || free_ff) begin
                     slot       = hit_ff ? hit_idx_ff : free_idx_ff;
                     base_count = hit_ff ? hit_entry_ff.fail_tally : 8'd0;
                     next_count = (base_count == abt_pkg::COUNT_MAX) ?
                                  base_count : base_count + 8'd1;
                     new_entry.address    = addr_ff;
                     new_entry.fail_tally = next_count;
                     new_entry.ban_active = hit_ff && hit_entry_ff.ban_active;
                     new_entry.ban_until  = hit_ff ? hit_entry_ff.ban_until : 33'd0;
                     if (next_count >= max_fails_ff) begin
                        new_entry.ban_active = 1'b1;
                        new_entry.ban_until  = {1'b0, now_ff} + {1'b0, ban_seconds_ff};
                        res.ban_started      = 1'b1;
                     end
                     ram_we          = 1'b1;
                     ram_waddr       = slot;
                     ram_wdata       = new_entry;
                     valid_in[slot]  = 1'b1;
                     res.fail_total  = next_count;
                  end else begin
                     res.dropped_full = 1'b1;
                  end
               end
               abt_pkg::OP_OK: begin
                  if (hit_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                  end
               end
               abt_pkg::OP_CLEAR: begin
                  valid_in = '0;
               end
            endcase
            pend_in  = res;
            state_in = abt_pkg::ST_POST;
         end
         abt_pkg::ST_POST: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = pend_ff;
               state_in      = abt_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= abt_pkg::ST_IDLE;
         issue_cnt_ff  <= '0;
         proc_vld_ff   <= 1'b0;
         valid_ff      <= '0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_cnt_ff  <= issue_cnt_in;
         proc_vld_ff   <= proc_vld_in;
         valid_ff      <= valid_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      now_ff       <= now_in;
      proc_idx_ff  <= proc_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      free_idx_ff  <= free_idx_in;
      pend_ff      <= pend_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_fails_ff   <= abt_pkg::MAX_FAILS_RESET;
         ban_seconds_ff <= abt_pkg::BAN_SECONDS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            abt_pkg::CSR_MAX_FAILS:   max_fails_ff   <= csr_wdata[7:0];
            abt_pkg::CSR_BAN_SECONDS: ban_seconds_ff <= csr_wdata;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_walk_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == abt_pkg::ST_WALK) |-> $past(req_tvalid && req_tready))
      else $error("walk started without an input transaction");

   a_walk_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abt_pkg::ST_WALK) |-> (issue_cnt_ff <= CNT_END))
      else $error("walk counter ran past the table");

   a_drop_no_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.dropped_full) |-> (rsp_data_ff.fail_total == 8'd0))
      else $error("dropped failure reports a count");

   a_ban_has_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.ban_started) |-> (rsp_data_ff.fail_total != 8'd0))
      else $error("ban started with zero count");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_data_ff.is_banned &&
                       (rsp_data_ff.dropped_full || rsp_data_ff.ban_started)))
      else $error("check and failure flags mixed in one result");
`endif

endmodule

@@ hdl/abt_ram.sv @@
// generic single-write, single-read ram with registered read data
module abt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
